// ===== src/correlated_clock_converter_core_macros.svh =====
// Assertion macros for the correlated clock converter checker.
`ifndef CORRELATED_CLOCK_CONVERTER_CORE_MACROS_SVH
`define CORRELATED_CLOCK_CONVERTER_CORE_MACROS_SVH

// Checked property, inactive while reset is asserted.
`define CCC_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ccc check failed");

// Checked property that also covers the reset cycles.
`define CCC_CHECK_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("ccc reset check failed");

`endif

// ===== src/ccc_pkg.sv =====
// Types and constants shared by the correlated clock converter files.
package ccc_pkg;

    localparam int TICK_W     = 64;
    localparam int RATE_W     = 32;
    localparam int NUM1_W     = 128;
    localparam int DEN1_W     = 64;
    localparam int NUM2_W     = 96;
    localparam int DEN2_W     = 32;
    localparam int PRE_STAGES = 6;
    localparam int MID_STAGES = 4;
    localparam int LATENCY    = PRE_STAGES + NUM1_W + MID_STAGES + NUM2_W + 1;

    localparam logic [TICK_W-1:0] ALL_ONES   = '1;
    localparam logic [RATE_W-1:0] NS_PER_SEC = 32'd1000000000;

    typedef enum logic [1:0] {
        REQ_P2C,
        REQ_C2P,
        REQ_ERR,
        REQ_CHG
    } t_req_e;

    typedef enum logic [2:0] {
        CFG_PARENT_RATE,
        CFG_CHILD_RATE,
        CFG_SPEED,
        CFG_CORR_PARENT,
        CFG_CORR_CHILD,
        CFG_INIT_ERR,
        CFG_ERR_GROWTH,
        CFG_THRESHOLD
    } t_cfg_e;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [63:0]       ticks;
        logic [63:0]       new_corr_parent_ticks;
        logic [63:0]       new_corr_child_ticks;
        logic signed [31:0] new_speed;
    } t_req_item;

    typedef struct packed {
        logic [63:0] result_ticks;
        logic        result_valid;
        logic [63:0] error_ns;
        logic [63:0] change_ns;
        logic        significant;
    } t_rsp_item;

    // Context carried through the conversion divider.
    typedef struct packed {
        t_req_e      req;
        logic        neg;
        logic        zmatch;
        logic        spd_ne;
        logic [63:0] aux;
    } t_ctx1;

    // Context carried through the error / change divider.
    typedef struct packed {
        t_req_e      req;
        logic        rt_valid;
        logic        spd_ne;
        logic [63:0] rt;
    } t_ctx2;

endpackage

// ===== src/correlated_clock_converter_core.sv =====
// Top level of the correlated clock timestamp converter.
//
//  channel   | handshake          | payload        | direction
//  ----------+--------------------+----------------+----------
//  request   | start / busy       | i_req          | in
//  result    | o_done (strobe)    | o_rsp          | out
//  config    | i_cfg_we           | i_cfg_idx/data | in
//
// One request per cycle is taken while busy is low; each result passes in order
// through registers S1 to S6, the conversion divider, E1 to E4, the scaling divider
// and F; the bit-serial dividers have 128 stages for the conversion, 96 for scaling.
// Reset is synchronous; busy is high during reset and falls in the cycle after release.
// Results are a one-cycle strobe; nothing stalls, so busy never rises in use.
module correlated_clock_converter_core #(
    parameter int SPEED_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ccc_pkg::t_req_item  i_req,
    output logic                o_done,
    output ccc_pkg::t_rsp_item  o_rsp,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);

    localparam int CTX1_W = $bits(ccc_pkg::t_ctx1);
    localparam int CTX2_W = $bits(ccc_pkg::t_ctx2);

    // ---------------------------------------------------------------- config
    logic [31:0] r_parent_rate, r_child_rate, r_speed;
    logic [63:0] r_corr_parent, r_corr_child;
    logic [31:0] r_init_err, r_err_growth, r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parent_rate <= 32'd1000000000;
            r_child_rate  <= 32'd90000;
            r_speed       <= 32'd65536;
            r_corr_parent <= '0;
            r_corr_child  <= '0;
            r_init_err    <= '0;
            r_err_growth  <= '0;
            r_threshold   <= '0;
        end else if (i_cfg_we) begin
            unique case (ccc_pkg::t_cfg_e'(i_cfg_idx))
                ccc_pkg::CFG_PARENT_RATE: r_parent_rate <= i_cfg_data[31:0];
                ccc_pkg::CFG_CHILD_RATE:  r_child_rate  <= i_cfg_data[31:0];
                ccc_pkg::CFG_SPEED:       r_speed       <= i_cfg_data[31:0];
                ccc_pkg::CFG_CORR_PARENT: r_corr_parent <= i_cfg_data;
                ccc_pkg::CFG_CORR_CHILD:  r_corr_child  <= i_cfg_data;
                ccc_pkg::CFG_INIT_ERR:    r_init_err    <= i_cfg_data[31:0];
                ccc_pkg::CFG_ERR_GROWTH:  r_err_growth  <= i_cfg_data[31:0];
                ccc_pkg::CFG_THRESHOLD:   r_threshold   <= i_cfg_data[31:0];
            endcase
        end
    end

    // zero rates count as one; speed as sign and magnitude
    logic [31:0] pr, cr, smag;
    logic        spd_zero;
    assign pr       = (r_parent_rate == '0) ? 32'd1 : r_parent_rate;
    assign cr       = (r_child_rate == '0) ? 32'd1 : r_child_rate;
    assign smag     = r_speed[31] ? (~r_speed + 32'd1) : r_speed;
    assign spd_zero = (r_speed == '0);

    // divisors depend on config only; refreshed every cycle
    logic [63:0] r_den_p2c, r_den_c2p;
    always_ff @(posedge i_clk) begin
        r_den_p2c <= 64'(pr) << SPEED_FRAC_BITS;
        r_den_c2p <= 64'(cr) * 64'(smag);
    end

    // ---------------------------------------------------------------- intake
    logic r_busy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    logic               r_s1_vld;
    ccc_pkg::t_req_item r_s1_item;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end
    always_ff @(posedge i_clk) begin
        r_s1_item <= i_req;
    end

    // S1: signed offset from the correlation point
    ccc_pkg::t_req_e s1_req;
    logic [63:0]     s1_t, s1_base, s1_mag;
    logic            s1_dneg;
    ccc_pkg::t_ctx1  s1_ctx;

    always_comb begin
        s1_req  = ccc_pkg::t_req_e'(r_s1_item.req_type);
        s1_t    = (s1_req == ccc_pkg::REQ_CHG) ? r_s1_item.new_corr_child_ticks
                                               : r_s1_item.ticks;
        s1_base = (s1_req == ccc_pkg::REQ_P2C) ? r_corr_parent : r_corr_child;
        s1_dneg = s1_t < s1_base;
        s1_mag  = s1_dneg ? (s1_base - s1_t) : (s1_t - s1_base);
        s1_ctx.req    = s1_req;
        s1_ctx.neg    = s1_dneg ^ r_speed[31];
        s1_ctx.zmatch = (s1_t == r_corr_child);
        s1_ctx.spd_ne = ($unsigned(r_s1_item.new_speed) != r_speed);
        s1_ctx.aux    = spd_zero ? r_s1_item.new_corr_child_ticks
                                 : r_s1_item.new_corr_parent_ticks;
    end

    logic           r_s2_vld;
    logic [63:0]    r_s2_mag;
    ccc_pkg::t_ctx1 r_s2_ctx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_s2_mag <= s1_mag;
        r_s2_ctx <= s1_ctx;
    end

    // S2: offset times the first rate, as two 32x32 partials
    logic [31:0] s2_m1;
    assign s2_m1 = (r_s2_ctx.req == ccc_pkg::REQ_P2C) ? cr : pr;

    logic           r_s3_vld;
    logic [63:0]    r_s3_pp0, r_s3_pp1;
    ccc_pkg::t_ctx1 r_s3_ctx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_s3_pp0 <= 64'(r_s2_mag[31:0]) * 64'(s2_m1);
        r_s3_pp1 <= 64'(r_s2_mag[63:32]) * 64'(s2_m1);
        r_s3_ctx <= r_s2_ctx;
    end

    // S3: partial sum
    logic           r_s4_vld;
    logic [95:0]    r_s4_prod;
    ccc_pkg::t_ctx1 r_s4_ctx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_s4_prod <= {32'b0, r_s3_pp0} + {r_s3_pp1, 32'b0};
        r_s4_ctx  <= r_s3_ctx;
    end

    // S4: times speed (p2c) or the fraction scale (c2p, error and change)
    logic [31:0] s4_m2;
    assign s4_m2 = (r_s4_ctx.req == ccc_pkg::REQ_P2C) ? smag
                                                       : (32'd1 << SPEED_FRAC_BITS);

    logic           r_s5_vld;
    logic [63:0]    r_s5_q0, r_s5_q1, r_s5_q2;
    ccc_pkg::t_ctx1 r_s5_ctx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_s5_q0  <= 64'(r_s4_prod[31:0]) * 64'(s4_m2);
        r_s5_q1  <= 64'(r_s4_prod[63:32]) * 64'(s4_m2);
        r_s5_q2  <= 64'(r_s4_prod[95:64]) * 64'(s4_m2);
        r_s5_ctx <= r_s4_ctx;
    end

    // S5: numerator sum and divisor pick
    logic           r_s6_vld;
    logic [127:0]   r_s6_num;
    logic [63:0]    r_s6_den;
    ccc_pkg::t_ctx1 r_s6_ctx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_s6_num <= {64'b0, r_s5_q0} + {32'b0, r_s5_q1, 32'b0} + {r_s5_q2, 64'b0};
        r_s6_den <= (r_s5_ctx.req == ccc_pkg::REQ_P2C) ? r_den_p2c : r_den_c2p;
        r_s6_ctx <= r_s5_ctx;
    end

    // ---------------------------------------------------------------- divide 1
    logic                           d1_vld;
    logic [ccc_pkg::NUM1_W-1:0]     d1_quo;
    logic [CTX1_W-1:0]              d1_side;
    ccc_pkg::t_ctx1                 d1_ctx;

    ccc_div #(
        .NUM_W  (ccc_pkg::NUM1_W),
        .DEN_W  (ccc_pkg::DEN1_W),
        .SIDE_W (CTX1_W)
    ) u_div_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s6_vld),
        .i_num   (r_s6_num),
        .i_den   (r_s6_den),
        .i_side  (r_s6_ctx),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );
    assign d1_ctx = d1_side;

    // E1: apply offset with saturation; speed zero handled apart for all but p2c
    logic        e1_qhi, e1_p2c, e1_rv;
    logic [63:0] e1_q, e1_base, e1_off, e1_rt;

    always_comb begin
        e1_qhi  = |d1_quo[127:64];
        e1_q    = d1_quo[63:0];
        e1_p2c  = (d1_ctx.req == ccc_pkg::REQ_P2C);
        e1_base = e1_p2c ? r_corr_child : r_corr_parent;
        if (d1_ctx.neg) begin
            e1_off = (e1_qhi || e1_q > e1_base) ? '0 : e1_base - e1_q;
        end else begin
            e1_off = (e1_qhi || e1_q > ~e1_base) ? ccc_pkg::ALL_ONES : e1_base + e1_q;
        end
        if (!e1_p2c && spd_zero) begin
            e1_rv = d1_ctx.zmatch;
            e1_rt = d1_ctx.zmatch ? r_corr_parent : '0;
        end else begin
            e1_rv = 1'b1;
            e1_rt = e1_off;
        end
    end

    logic           r_e1_vld;
    ccc_pkg::t_ctx2 r_e1_ctx;
    logic [63:0]    r_e1_aux;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else begin
            r_e1_vld <= d1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_e1_ctx.req      <= d1_ctx.req;
        r_e1_ctx.rt_valid <= e1_rv;
        r_e1_ctx.spd_ne   <= d1_ctx.spd_ne;
        r_e1_ctx.rt       <= e1_rt;
        r_e1_aux          <= d1_ctx.aux;
    end

    // E2: distance to scale; error uses growth / parent rate, change 1e9 / rate
    logic        e2_err, e2_chg0;
    logic [63:0] e2_x, e2_y, e2_delta;

    always_comb begin
        e2_err   = (r_e1_ctx.req == ccc_pkg::REQ_ERR);
        e2_chg0  = (r_e1_ctx.req == ccc_pkg::REQ_CHG) && spd_zero;
        e2_x     = e2_err ? r_e1_ctx.rt : r_e1_aux;
        e2_y     = e2_err ? r_corr_parent : (spd_zero ? r_corr_child : r_e1_ctx.rt);
        e2_delta = (e2_x < e2_y) ? (e2_y - e2_x) : (e2_x - e2_y);
    end

    logic           r_e2_vld;
    logic [63:0]    r_e2_delta;
    logic [31:0]    r_e2_mul, r_e2_den;
    ccc_pkg::t_ctx2 r_e2_ctx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e2_vld <= 1'b0;
        end else begin
            r_e2_vld <= r_e1_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_e2_delta <= e2_delta;
        r_e2_mul   <= e2_err ? r_err_growth : ccc_pkg::NS_PER_SEC;
        r_e2_den   <= e2_chg0 ? cr : pr;
        r_e2_ctx   <= r_e1_ctx;
    end

    // E3: partial products
    logic           r_e3_vld;
    logic [63:0]    r_e3_pp0, r_e3_pp1;
    logic [31:0]    r_e3_den;
    ccc_pkg::t_ctx2 r_e3_ctx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_vld <= 1'b0;
        end else begin
            r_e3_vld <= r_e2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_e3_pp0 <= 64'(r_e2_delta[31:0]) * 64'(r_e2_mul);
        r_e3_pp1 <= 64'(r_e2_delta[63:32]) * 64'(r_e2_mul);
        r_e3_den <= r_e2_den;
        r_e3_ctx <= r_e2_ctx;
    end

    // E4: partial sum
    logic           r_e4_vld;
    logic [95:0]    r_e4_prod;
    logic [31:0]    r_e4_den;
    ccc_pkg::t_ctx2 r_e4_ctx;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e4_vld <= 1'b0;
        end else begin
            r_e4_vld <= r_e3_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_e4_prod <= {32'b0, r_e3_pp0} + {r_e3_pp1, 32'b0};
        r_e4_den  <= r_e3_den;
        r_e4_ctx  <= r_e3_ctx;
    end

    // ---------------------------------------------------------------- divide 2
    logic                       d2_vld;
    logic [ccc_pkg::NUM2_W-1:0] d2_quo;
    logic [CTX2_W-1:0]          d2_side;
    ccc_pkg::t_ctx2             d2_ctx;

    ccc_div #(
        .NUM_W  (ccc_pkg::NUM2_W),
        .DEN_W  (ccc_pkg::DEN2_W),
        .SIDE_W (CTX2_W)
    ) u_div_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e4_vld),
        .i_num   (r_e4_prod),
        .i_den   (r_e4_den),
        .i_side  (r_e4_ctx),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );
    assign d2_ctx = d2_side;

    // F: assemble the result; fields not owned by the request stay zero
    logic [63:0]        f_q, f_init;
    ccc_pkg::t_rsp_item f_rsp;

    always_comb begin
        f_q    = (|d2_quo[95:64]) ? ccc_pkg::ALL_ONES : d2_quo[63:0];
        f_init = 64'(r_init_err);
        f_rsp  = '0;
        unique case (d2_ctx.req) inside
            ccc_pkg::REQ_P2C, ccc_pkg::REQ_C2P: begin
                f_rsp.result_ticks = d2_ctx.rt;
                f_rsp.result_valid = d2_ctx.rt_valid;
            end
            ccc_pkg::REQ_ERR: begin
                f_rsp.result_ticks = d2_ctx.rt;
                f_rsp.result_valid = d2_ctx.rt_valid;
                if (!d2_ctx.rt_valid || f_q > ~f_init) begin
                    f_rsp.error_ns = ccc_pkg::ALL_ONES;
                end else begin
                    f_rsp.error_ns = f_q + f_init;
                end
            end
            ccc_pkg::REQ_CHG: begin
                f_rsp.change_ns   = d2_ctx.spd_ne ? ccc_pkg::ALL_ONES : f_q;
                f_rsp.significant = f_rsp.change_ns > 64'(r_threshold);
            end
            default: begin
                f_rsp = '0;
            end
        endcase
    end

    logic               r_f_vld;
    ccc_pkg::t_rsp_item r_f_rsp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else begin
            r_f_vld <= d2_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        r_f_rsp <= f_rsp;
    end

    assign o_done = r_f_vld;
    assign o_rsp  = r_f_rsp;

endmodule

// ===== src/ccc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module ccc_div #(
    parameter int NUM_W  = 128,
    parameter int DEN_W  = 64,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    // acc shifts the numerator out at the top and the quotient in at the bottom
    logic              r_vld  [NUM_W];
    logic [NUM_W-1:0]  r_acc  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic              s_vld;
        logic [NUM_W-1:0]  s_acc;
        logic [DEN_W-1:0]  s_rem;
        logic [DEN_W-1:0]  s_den;
        logic [SIDE_W-1:0] s_side;
        logic [DEN_W:0]    trial;
        logic              fits;

        if (k == 0) begin : g_src
            assign s_vld  = i_valid;
            assign s_acc  = i_num;
            assign s_rem  = '0;
            assign s_den  = i_den;
            assign s_side = i_side;
        end else begin : g_src
            assign s_vld  = r_vld[k-1];
            assign s_acc  = r_acc[k-1];
            assign s_rem  = r_rem[k-1];
            assign s_den  = r_den[k-1];
            assign s_side = r_side[k-1];
        end

        assign trial = {s_rem, s_acc[NUM_W-1]};
        assign fits  = trial >= {1'b0, s_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= DEN_W'(fits ? trial - {1'b0, s_den} : trial);
            r_acc[k]  <= {s_acc[NUM_W-2:0], fits};
            r_den[k]  <= s_den;
            r_side[k] <= s_side;
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quo   = r_acc[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

// ===== src/ccc_chk.sv =====
// Port-level checker for the correlated clock converter, bound to the top level.
`include "correlated_clock_converter_core_macros.svh"

module ccc_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input ccc_pkg::t_rsp_item o_rsp
);

    // every transfer comes back after the fixed latency
    `CCC_CHECK(a_latency, (start && !busy) |-> ##(ccc_pkg::LATENCY) o_done)
    // no result without a transfer that far back
    `CCC_CHECK(a_no_orphan, o_done |-> $past(start && !busy, ccc_pkg::LATENCY))
    // a change check leaves the conversion and error fields clear
    `CCC_CHECK(a_sig_fields, (o_done && o_rsp.significant) |-> (!o_rsp.result_valid && o_rsp.result_ticks == '0 && o_rsp.error_ns == '0))
    // busy covers the cycle after reset
    `CCC_CHECK_RST(a_busy_rst, !i_rst_n |=> busy)

endmodule

bind correlated_clock_converter_core ccc_chk u_chk (.*);
